@@ src/dual_channel_byte_dma_regs_top_macros.svh @@
// Assertion macros shared by the checker of the byte DMA register block.
// Each macro expands to one labelled concurrent assertion.
`ifndef DUAL_CHANNEL_BYTE_DMA_REGS_TOP_MACROS_SVH
`define DUAL_CHANNEL_BYTE_DMA_REGS_TOP_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define DCBDR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define DCBDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/dcbdr_pkg.sv @@
// ---------------------------------------------------------------------------
// dcbdr_pkg
// Types and constants shared by the byte DMA register block.
// ---------------------------------------------------------------------------
package dcbdr_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [3:0] REG_CONTROL   = 4'd0;
  localparam logic [3:0] REG_CONFIG    = 4'd1;
  localparam logic [3:0] REG_REVISION  = 4'd2;
  localparam logic [3:0] REG_RX_BUFFER = 4'd3;
  localparam logic [3:0] REG_RX_HOST   = 4'd4;
  localparam logic [3:0] REG_RX_COUNT  = 4'd5;
  localparam logic [3:0] REG_TX_BUFFER = 4'd6;
  localparam logic [3:0] REG_TX_HOST   = 4'd7;
  localparam logic [3:0] REG_TX_COUNT  = 4'd8;

  localparam int CTRL_W = 15;

  localparam logic [CTRL_W-1:0] EN_MASK  = 15'h7f00;
  localparam logic [CTRL_W-1:0] CLR_MASK = 15'h00f0;
  localparam logic [CTRL_W-1:0] RX_DONE  = 15'h0040;
  localparam logic [CTRL_W-1:0] TX_DONE  = 15'h0020;
  localparam logic [CTRL_W-1:0] EXT_BIT  = 15'h0001;
  localparam logic [CTRL_W-1:0] IRQ_MASK = EXT_BIT | RX_DONE | TX_DONE;

  localparam logic [31:0] COUNT_BASE = 32'h8000_0000;
  localparam logic [31:0] COUNT_LAST = COUNT_BASE + 32'd1;

  typedef struct packed {
    op_t         op;
    logic [3:0]  idx;
    logic [31:0] data;
  } cmd_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
    logic        rx_move;
    logic [15:0] rx_from_buffer;
    logic [31:0] rx_to_host;
    logic        tx_move;
    logic [31:0] tx_from_host;
    logic [15:0] tx_to_buffer;
  } res_t;

endpackage

@@ src/dcbdr_front.sv @@
// ---------------------------------------------------------------------------
// dcbdr_front
// Accepts input transactions and classifies them into commands.
// ---------------------------------------------------------------------------
module dcbdr_front (
  input  logic               in_valid,
  input  logic [1:0]         in_req_type,
  input  logic [3:0]         in_reg_index,
  input  logic [31:0]        in_write_data,
  input  logic               q_full,
  output logic               in_stall,
  output logic               push,
  output dcbdr_pkg::cmd_t    push_cmd
);

  logic idx_ok;

  // Revision and indexes past the last register behave as no operation.
  assign idx_ok = (in_reg_index <= dcbdr_pkg::REG_TX_COUNT) &&
                  (in_reg_index != dcbdr_pkg::REG_REVISION);

  always_comb begin
    push_cmd.idx  = in_reg_index;
    push_cmd.data = in_write_data;
    case (in_req_type)
      dcbdr_pkg::REQ_READ:  push_cmd.op = idx_ok ? dcbdr_pkg::OP_READ  : dcbdr_pkg::OP_NOP;
      dcbdr_pkg::REQ_WRITE: push_cmd.op = idx_ok ? dcbdr_pkg::OP_WRITE : dcbdr_pkg::OP_NOP;
      dcbdr_pkg::REQ_TICK:  push_cmd.op = dcbdr_pkg::OP_TICK;
      default:              push_cmd.op = dcbdr_pkg::OP_NOP;
    endcase
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

endmodule

@@ src/dcbdr_queue.sv @@
// ---------------------------------------------------------------------------
// dcbdr_queue
// Short command queue between the front end and the back end.
// ---------------------------------------------------------------------------
module dcbdr_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dcbdr_pkg::cmd_t    push_cmd,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output dcbdr_pkg::cmd_t    pop_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  dcbdr_pkg::cmd_t slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;

  assign full    = (fill_r == CW'(DEPTH));
  assign q_valid = (fill_r != '0);
  assign pop_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CW'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ src/dcbdr_back.sv @@
// ---------------------------------------------------------------------------
// dcbdr_back
// Register file and DMA channels; executes one command per cycle into an
// output register while that register is free or not stalled.
// ---------------------------------------------------------------------------
module dcbdr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  dcbdr_pkg::cmd_t    cmd,
  output logic               pop,
  input  logic               out_stall,
  output logic               out_valid,
  output dcbdr_pkg::res_t    res
);

  logic [dcbdr_pkg::CTRL_W-1:0] ctrl_r, ctrl_nxt;
  logic [31:0] cfg_r, cfg_nxt;
  logic [31:0] rx_buf_r, rx_buf_nxt;
  logic [31:0] rx_host_r, rx_host_nxt;
  logic [31:0] rx_cnt_r, rx_cnt_nxt;
  logic [31:0] tx_buf_r, tx_buf_nxt;
  logic [31:0] tx_host_r, tx_host_nxt;
  logic [31:0] tx_cnt_r, tx_cnt_nxt;
  logic        out_valid_r;
  dcbdr_pkg::res_t res_r, res_nxt;
  logic        rx_act, tx_act;
  logic [dcbdr_pkg::CTRL_W-1:0] wr_ctrl;

  assign pop       = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign res       = res_r;

  // Active when the count lies strictly above the base value.
  assign rx_act  = rx_cnt_r[31] && (rx_cnt_r[30:0] != '0);
  assign tx_act  = tx_cnt_r[31] && (tx_cnt_r[30:0] != '0);
  assign wr_ctrl = cmd.data[dcbdr_pkg::CTRL_W-1:0];

  always_comb begin
    ctrl_nxt    = ctrl_r;
    cfg_nxt     = cfg_r;
    rx_buf_nxt  = rx_buf_r;
    rx_host_nxt = rx_host_r;
    rx_cnt_nxt  = rx_cnt_r;
    tx_buf_nxt  = tx_buf_r;
    tx_host_nxt = tx_host_r;
    tx_cnt_nxt  = tx_cnt_r;
    res_nxt     = '0;
    case (cmd.op)
      dcbdr_pkg::OP_READ: begin
        case (cmd.idx)
          dcbdr_pkg::REG_CONTROL:   res_nxt.read_data = {17'd0, ctrl_r};
          dcbdr_pkg::REG_CONFIG:    res_nxt.read_data = cfg_r;
          dcbdr_pkg::REG_RX_BUFFER: res_nxt.read_data = rx_buf_r;
          dcbdr_pkg::REG_RX_HOST:   res_nxt.read_data = rx_host_r;
          dcbdr_pkg::REG_RX_COUNT:  res_nxt.read_data = rx_cnt_r;
          dcbdr_pkg::REG_TX_BUFFER: res_nxt.read_data = tx_buf_r;
          dcbdr_pkg::REG_TX_HOST:   res_nxt.read_data = tx_host_r;
          dcbdr_pkg::REG_TX_COUNT:  res_nxt.read_data = tx_cnt_r;
          default:                  res_nxt.read_data = '0;
        endcase
      end
      dcbdr_pkg::OP_WRITE: begin
        case (cmd.idx)
          dcbdr_pkg::REG_CONTROL: begin
            // Enables are replaced; a status bit survives only where a one is written.
            ctrl_nxt = (ctrl_r & ~dcbdr_pkg::EN_MASK) | (wr_ctrl & dcbdr_pkg::EN_MASK);
            ctrl_nxt = ctrl_nxt & (~dcbdr_pkg::CLR_MASK | (wr_ctrl & dcbdr_pkg::CLR_MASK));
          end
          dcbdr_pkg::REG_CONFIG:    cfg_nxt     = cmd.data;
          dcbdr_pkg::REG_RX_BUFFER: rx_buf_nxt  = cmd.data;
          dcbdr_pkg::REG_RX_HOST:   rx_host_nxt = cmd.data;
          dcbdr_pkg::REG_RX_COUNT:  rx_cnt_nxt  = cmd.data;
          dcbdr_pkg::REG_TX_BUFFER: tx_buf_nxt  = cmd.data;
          dcbdr_pkg::REG_TX_HOST:   tx_host_nxt = cmd.data;
          dcbdr_pkg::REG_TX_COUNT:  tx_cnt_nxt  = cmd.data;
          default: ;
        endcase
      end
      dcbdr_pkg::OP_TICK: begin
        if (rx_act) begin
          res_nxt.rx_move        = 1'b1;
          res_nxt.rx_from_buffer = rx_buf_r[15:0];
          res_nxt.rx_to_host     = rx_host_r;
          rx_buf_nxt             = rx_buf_r + 32'd1;
          rx_host_nxt            = rx_host_r + 32'd1;
          if (rx_cnt_r == dcbdr_pkg::COUNT_LAST) begin
            rx_cnt_nxt = '0;
            ctrl_nxt   = ctrl_nxt | dcbdr_pkg::RX_DONE;
          end else begin
            rx_cnt_nxt = rx_cnt_r - 32'd1;
          end
        end
        if (tx_act) begin
          res_nxt.tx_move      = 1'b1;
          res_nxt.tx_from_host = tx_host_r;
          res_nxt.tx_to_buffer = tx_buf_r[15:0];
          tx_buf_nxt           = tx_buf_r + 32'd1;
          tx_host_nxt          = tx_host_r + 32'd1;
          if (tx_cnt_r == dcbdr_pkg::COUNT_LAST) begin
            tx_cnt_nxt = '0;
            ctrl_nxt   = ctrl_nxt | dcbdr_pkg::TX_DONE;
          end else begin
            tx_cnt_nxt = tx_cnt_r - 32'd1;
          end
        end
      end
      default: ;
    endcase
    res_nxt.irq_level = (ctrl_nxt & dcbdr_pkg::IRQ_MASK) != '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= '0;
      cfg_r       <= '0;
      rx_buf_r    <= '0;
      rx_host_r   <= '0;
      rx_cnt_r    <= '0;
      tx_buf_r    <= '0;
      tx_host_r   <= '0;
      tx_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        ctrl_r      <= ctrl_nxt;
        cfg_r       <= cfg_nxt;
        rx_buf_r    <= rx_buf_nxt;
        rx_host_r   <= rx_host_nxt;
        rx_cnt_r    <= rx_cnt_nxt;
        tx_buf_r    <= tx_buf_nxt;
        tx_host_r   <= tx_host_nxt;
        tx_cnt_r    <= tx_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

@@ src/dual_channel_byte_dma_regs_top.sv @@
// ---------------------------------------------------------------------------
// dual_channel_byte_dma_regs_top
// Register file with a receive and a transmit byte DMA channel.
// ---------------------------------------------------------------------------
// A result is registered in the back end's output register after its command
// has passed the command queue. One transaction per cycle is sustained while
// out_stall stays low; the back end updates all registers and both channels per command.
// The command queue holds QUEUE_DEPTH transactions between front and back end.
// Reset (rst_n low, synchronous): all registers read zero, the queue is empty
// and the output holds no transaction.
// ---------------------------------------------------------------------------
module dual_channel_byte_dma_regs_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_reg_index,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_irq_level,
  output logic        out_rx_move,
  output logic [15:0] out_rx_from_buffer,
  output logic [31:0] out_rx_to_host,
  output logic        out_tx_move,
  output logic [31:0] out_tx_from_host,
  output logic [15:0] out_tx_to_buffer
);

  // The front end turns each request into a command: reads and writes of
  // the revision word or of an index past the last register are reduced to
  // no operation, as is the unused request type.
  logic            push, q_full, pop, q_valid;
  dcbdr_pkg::cmd_t push_cmd, pop_cmd;
  dcbdr_pkg::res_t res;

  dcbdr_front u_front (
    .in_valid      (in_valid),
    .in_req_type   (in_req_type),
    .in_reg_index  (in_reg_index),
    .in_write_data (in_write_data),
    .q_full        (q_full),
    .in_stall      (in_stall),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  // The queue decouples the input stall from the output stall, so that
  // in_stall depends only on the queue fill and never on out_stall.
  dcbdr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .pop_cmd  (pop_cmd)
  );

  // The back end executes a command whenever the output register is free or
  // is being emptied in the same cycle, and registers the result there.
  dcbdr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .cmd       (pop_cmd),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_read_data      = res.read_data;
  assign out_irq_level      = res.irq_level;
  assign out_rx_move        = res.rx_move;
  assign out_rx_from_buffer = res.rx_from_buffer;
  assign out_rx_to_host     = res.rx_to_host;
  assign out_tx_move        = res.tx_move;
  assign out_tx_from_host   = res.tx_from_host;
  assign out_tx_to_buffer   = res.tx_to_buffer;

endmodule

@@ src/dcbdr_checker.sv @@
// ---------------------------------------------------------------------------
// dcbdr_checker
// Port-level checks of the byte DMA register block, bound to the top level.
// ---------------------------------------------------------------------------
`include "dual_channel_byte_dma_regs_top_macros.svh"

module dcbdr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_read_data,
  input logic        out_rx_move,
  input logic [15:0] out_rx_from_buffer,
  input logic [31:0] out_rx_to_host,
  input logic        out_tx_move,
  input logic [31:0] out_tx_from_host,
  input logic [15:0] out_tx_to_buffer
);

  `DCBDR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "stalled result dropped")
  `DCBDR_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_read_data), "stalled result changed")
  `DCBDR_ASSERT_NOW(a_rx_idle_zero, clk, rst_n, out_valid && !out_rx_move, (out_rx_from_buffer == 16'd0) && (out_rx_to_host == 32'd0), "receive fields set without a move")
  `DCBDR_ASSERT_NOW(a_tx_idle_zero, clk, rst_n, out_valid && !out_tx_move, (out_tx_from_host == 32'd0) && (out_tx_to_buffer == 16'd0), "transmit fields set without a move")
  `DCBDR_ASSERT_NOW(a_move_no_read, clk, rst_n, out_valid && (out_rx_move || out_tx_move), out_read_data == 32'd0, "read data on a tick result")

endmodule

bind dual_channel_byte_dma_regs_top dcbdr_checker u_dcbdr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_read_data      (out_read_data),
  .out_rx_move        (out_rx_move),
  .out_rx_from_buffer (out_rx_from_buffer),
  .out_rx_to_host     (out_rx_to_host),
  .out_tx_move        (out_tx_move),
  .out_tx_from_host   (out_tx_from_host),
  .out_tx_to_buffer   (out_tx_to_buffer)
);
